/* rtl/oust_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oust_pkg
// Shared types and codes for the ordered unique set table.
// ----------------------------------------------------------------------------
package oust_pkg;

   localparam int CAPACITY_DEF      = 16;
   localparam int ELEMENT_WIDTH_DEF = 32;

   // operation codes
   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_SEARCH = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_FIRST  = 3'd3;
   localparam logic [2:0] OP_NEXT   = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_EMPTY        = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
   localparam logic [2:0] ST_FULL         = 3'd3;
   localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  found_index;
      logic [31:0] read_value;
      logic [4:0]  count;
   } rsp_type;

endpackage

/* rtl/oust_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oust_seq
// Entry memory and the sequencer that scans, appends and compacts it.
// ----------------------------------------------------------------------------
module oust_seq #(
   parameter int CAPACITY      = oust_pkg::CAPACITY_DEF,
   parameter int ELEMENT_WIDTH = oust_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  oust_pkg::req_type req_item,
   output logic              idle,
   input  logic              out_free,
   output logic              done,
   output oust_pkg::rsp_type result
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int EW = ELEMENT_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_READ,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [EW-1:0]    val_ff, val_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IW-1:0]    chk_idx_ff, chk_idx_in;
   logic [2:0]       status_ff, status_in;
   logic [3:0]       idx_ff, idx_in;
   logic [31:0]      rd_ff, rd_in;

   // memory port
   logic [EW-1:0]    mem [CAPACITY];
   logic [EW-1:0]    rdata_ff;
   logic             rd_en;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;

   logic             match;
   logic             more;
   logic             full;
   logic [CW-1:0]    cur_next;

   assign match    = chk_vld_ff && (rdata_ff == val_ff);
   assign more     = issue_ff < count_ff;
   assign full     = count_ff == CW'(CAPACITY);
   assign cur_next = (cursor_ff < CW'(CAPACITY)) ? cursor_ff + CW'(1) : cursor_ff;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      issue_in   = issue_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      status_in  = status_ff;
      idx_in     = idx_ff;
      rd_in      = rd_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = val_ff;
      done       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_item.op;
               val_in     = EW'(req_item.value);
               issue_in   = '0;
               chk_vld_in = 1'b0;
               status_in  = oust_pkg::ST_OK;
               idx_in     = '0;
               rd_in      = '0;
               case (req_item.op)
                  oust_pkg::OP_ADD: begin
                     state_in = S_SCAN;
                  end
                  oust_pkg::OP_SEARCH, oust_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = oust_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  oust_pkg::OP_FIRST: begin
                     if (count_ff == '0) begin
                        status_in = oust_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        cursor_in = '0;
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                        state_in  = S_READ;
                     end
                  end
                  oust_pkg::OP_NEXT: begin
                     cursor_in = cur_next;
                     if (cur_next >= count_ff) begin
                        status_in = oust_pkg::ST_OUT_OF_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_next[IW-1:0];
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     status_in = oust_pkg::ST_OUT_OF_RANGE;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // one read issued per cycle, its compare lands in the cycle after
         S_SCAN: begin
            if (match) begin
               case (op_ff)
                  oust_pkg::OP_SEARCH: begin
                     idx_in   = 4'(chk_idx_ff);
                     state_in = S_DONE;
                  end
                  oust_pkg::OP_REMOVE: begin
                     idx_in     = 4'(chk_idx_ff);
                     issue_in   = CW'(chk_idx_ff) + CW'(1);
                     chk_vld_in = 1'b0;
                     state_in   = S_SHIFT;
                  end
                  default: begin
                     // duplicate add: nothing stored
                     state_in = S_DONE;
                  end
               endcase
            end else if (more) begin
               rd_en      = 1'b1;
               rd_addr    = issue_ff[IW-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IW-1:0];
               issue_in   = issue_ff + CW'(1);
            end else begin
               chk_vld_in = 1'b0;
               state_in   = S_DONE;
               if (op_ff == oust_pkg::OP_ADD) begin
                  if (full) begin
                     status_in = oust_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IW-1:0];
                     wr_data  = val_ff;
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  status_in = oust_pkg::ST_NOT_FOUND;
               end
            end
         end

         // read entry i+1, write it back to i on the following cycle
         S_SHIFT: begin
            if (chk_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff;
               wr_data = rdata_ff;
            end
            if (more) begin
               rd_en      = 1'b1;
               rd_addr    = issue_ff[IW-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = IW'(issue_ff - CW'(1));
               issue_in   = issue_ff + CW'(1);
            end else begin
               chk_vld_in = 1'b0;
               count_in   = count_ff - CW'(1);
               state_in   = S_DONE;
            end
         end

         S_READ: begin
            rd_in    = 32'(rdata_ff);
            state_in = S_DONE;
         end

         S_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         chk_vld_ff <= chk_vld_in;
      end
      op_ff      <= op_in;
      val_ff     <= val_in;
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      idx_ff     <= idx_in;
      rd_ff      <= rd_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign idle               = state_ff == S_IDLE;
   assign result.status      = status_ff;
   assign result.found_index = idx_ff;
   assign result.read_value  = rd_ff;
   assign result.count       = 5'(count_ff);

endmodule

/* rtl/ordered_unique_set_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_unique_set_table_unit
// Set of unique values kept in insertion order, with a walk cursor.
// ----------------------------------------------------------------------------
// Flow, accept to rsp_valid: empty, out of range and unused op go straight to
// the result, first/next read one entry, add, search and remove scan the entries
// in order (one entry compared per cycle), and a remove hit then shifts the later entries down.
// One item in flight; the next is taken the cycle after the result enters the
// output register. Reset clears count, cursor and control; entry memory is
// not cleared.
module ordered_unique_set_table_unit #(
   parameter int CAPACITY      = oust_pkg::CAPACITY_DEF,
   parameter int ELEMENT_WIDTH = oust_pkg::ELEMENT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oust_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oust_pkg::rsp_type rsp_data
);

   logic              seq_idle;
   logic              seq_done;
   logic              out_free;
   oust_pkg::rsp_type seq_result;
   logic              rsp_valid_ff, rsp_valid_in;
   oust_pkg::rsp_type rsp_data_ff;

   assign req_ready = seq_idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   oust_seq #(
      .CAPACITY      (CAPACITY),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_valid && seq_idle),
      .req_item (req_data),
      .idle     (seq_idle),
      .out_free (out_free),
      .done     (seq_done),
      .result   (seq_result)
   );

   assign rsp_valid_in = (seq_done && out_free) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (seq_done && out_free) begin
         rsp_data_ff <= seq_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/oust_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oust_chk
// Port-level checks for the ordered unique set table, bound to the top level.
// ----------------------------------------------------------------------------
module oust_chk #(
   parameter int CAPACITY = oust_pkg::CAPACITY_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input oust_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input oust_pkg::rsp_type rsp_data
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == oust_pkg::ST_FULL |-> rsp_data.count == 5'(CAPACITY))
      else $error("full reported below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == oust_pkg::ST_EMPTY |-> rsp_data.count == 5'd0)
      else $error("empty reported with entries stored");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != oust_pkg::ST_OK
      |-> rsp_data.found_index == 4'd0 && rsp_data.read_value == 32'd0)
      else $error("failed item carries index or data");

endmodule

bind ordered_unique_set_table_unit oust_chk #(.CAPACITY(CAPACITY)) u_oust_chk (.*);
